[hw/rtl/pidarr_pkg.sv]
`default_nettype none

package pidarr_pkg;

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_INSERT  = 2'd1,
      FUNC_DELETE  = 2'd2,
      FUNC_DISPLAY = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_BADPOS = 2'd3
   } status_type;

   // what a cell does this cycle
   typedef enum logic [1:0] {
      ACT_HOLD  = 2'd0,
      ACT_LOAD  = 2'd1,   // take the inserted word
      ACT_LEFT  = 2'd2,   // take lower neighbor (shift up)
      ACT_RIGHT = 2'd3    // take upper neighbor (shift down / rotate)
   } cell_act_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SHOW = 1'b1
   } state_type;

   typedef struct packed {
      cell_act_type act;
      logic [31:0]  ins_value;
   } cell_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/pidarr_cell.sv]
`default_nettype none

module pidarr_cell (
   input  wire                       clock,
   input  pidarr_pkg::cell_ctl_type  ctl,
   input  wire  [31:0]               left_value,
   input  wire  [31:0]               right_value,
   output logic [31:0]               value
);

   logic [31:0] value_ff;
   logic [31:0] value_in;

   always_comb begin
      case (ctl.act)
         pidarr_pkg::ACT_LOAD:  value_in = ctl.ins_value;
         pidarr_pkg::ACT_LEFT:  value_in = left_value;
         pidarr_pkg::ACT_RIGHT: value_in = right_value;
         default:               value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[hw/rtl/positional_insert_delete_array_top.sv]
`default_nettype none

// Channel  Dir  Handshake             Word
// req_     in   req_valid/req_stall   func, position, data_value
// rsp_     out  rsp_valid/rsp_stall   status, out_value, entry_count, last
//
// Insert shifts cells above the position up, delete pulls cells at and above
// it down. A non-empty display rotates the row toward cell 0 until it is back
// in place, one word per held entry read from cell 0. rsp stalls hold the
// rotation only on steps that emit a word. A new req word is taken once the
// rotation is done and the rsp register is free or draining.
// Reset (sync, active high) clears count and control; entry cells are not reset.

module positional_insert_delete_array_top #(
   parameter int CAPACITY = 8
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_func,
   input  wire  [2:0]  req_position,
   input  wire  [31:0] req_data_value,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_value,
   output logic [3:0]  rsp_entry_count,
   output logic        rsp_last
);

   localparam int CW   = $clog2(CAPACITY + 1);      // count width
   localparam int SW   = $clog2(CAPACITY);          // rotation step width
   localparam int IW   = (CW > 3) ? CW : 3;         // position compare width
   localparam int XW   = (CW > 4) ? CW : 4;         // count output width
   localparam int NPOS = (CAPACITY < 8) ? CAPACITY : 8;  // addressable cells

   // ---------------------------------------------------------------- state
   pidarr_pkg::state_type  state_ff, state_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [CW-1:0]          count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   pidarr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_value_ff, rsp_value_in;
   logic [3:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- cells
   logic [31:0]              cell_value [CAPACITY];
   pidarr_pkg::cell_ctl_type cell_ctl   [CAPACITY];

   // ---------------------------------------------------------------- decode
   pidarr_pkg::func_type func;
   logic                 slot_free;
   logic                 req_take;
   logic [IW-1:0]        pos_x;
   logic [IW-1:0]        cnt_x;
   logic                 is_full;
   logic                 is_empty;
   logic                 ins_ok;
   logic                 del_ok;
   logic                 show_start;
   logic                 show_emit;
   logic                 show_adv;
   logic                 show_done;
   logic [31:0]          gone_value;
   logic [XW-1:0]        count_x;

   assign func      = pidarr_pkg::func_type'(req_func);
   // rsp register is free if empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pidarr_pkg::ST_IDLE) || !slot_free;
   assign req_take  = req_valid && !req_stall;

   assign pos_x    = IW'(req_position);
   assign cnt_x    = IW'(count_ff);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   assign ins_ok     = req_take && (func == pidarr_pkg::FUNC_INSERT) && !is_full
                       && !(pos_x > cnt_x);
   assign del_ok     = req_take && (func == pidarr_pkg::FUNC_DELETE) && !is_empty
                       && (pos_x < cnt_x);
   assign show_start = req_take && (func == pidarr_pkg::FUNC_DISPLAY) && !is_empty;

   // during display: the first count steps emit cell 0, the rest just rotate
   // the row back into place
   assign show_emit = (state_ff == pidarr_pkg::ST_SHOW) && (CW'(step_ff) < count_ff);
   assign show_adv  = (state_ff == pidarr_pkg::ST_SHOW) && (!show_emit || slot_free);
   assign show_done = show_adv && (step_ff == SW'(CAPACITY - 1));

   // deleted word: position is 3 bits, so only the low cells can be addressed
   always_comb begin
      gone_value = '0;
      for (int k = 0; k < NPOS; k++) begin
         if (req_position == 3'(k)) begin
            gone_value = cell_value[k];
         end
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         pidarr_pkg::ST_IDLE: begin
            if (show_start) begin
               state_in = pidarr_pkg::ST_SHOW;
               step_in  = '0;
            end
         end
         pidarr_pkg::ST_SHOW: begin
            if (show_done) begin
               state_in = pidarr_pkg::ST_IDLE;
            end else if (show_adv) begin
               step_in = step_ff + SW'(1);
            end
         end
         default: begin
            state_in = pidarr_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      count_in = count_ff;
      if (req_take) begin
         case (func)
            pidarr_pkg::FUNC_CLEAR:  count_in = '0;
            pidarr_pkg::FUNC_INSERT: if (ins_ok) count_in = count_ff + CW'(1);
            pidarr_pkg::FUNC_DELETE: if (del_ok) count_in = count_ff - CW'(1);
            default:                 count_in = count_ff;
         endcase
      end
   end

   // entry_count is the count masked to four bits
   assign count_x = XW'(count_in);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_take && !show_start) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = '0;
         rsp_count_in = count_x[3:0];
         rsp_last_in  = 1'b1;
         case (func)
            pidarr_pkg::FUNC_CLEAR: begin
               rsp_status_in = pidarr_pkg::STATUS_OK;
            end
            pidarr_pkg::FUNC_INSERT: begin
               if (is_full)
                  rsp_status_in = pidarr_pkg::STATUS_FULL;
               else if (!ins_ok)
                  rsp_status_in = pidarr_pkg::STATUS_BADPOS;
               else
                  rsp_status_in = pidarr_pkg::STATUS_OK;
            end
            pidarr_pkg::FUNC_DELETE: begin
               if (is_empty) begin
                  rsp_status_in = pidarr_pkg::STATUS_EMPTY;
               end else if (!del_ok) begin
                  rsp_status_in = pidarr_pkg::STATUS_BADPOS;
               end else begin
                  rsp_status_in = pidarr_pkg::STATUS_OK;
                  rsp_value_in  = gone_value;
               end
            end
            default: begin
               // display of an empty list
               rsp_status_in = pidarr_pkg::STATUS_EMPTY;
            end
         endcase
      end else if (show_adv && show_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pidarr_pkg::STATUS_OK;
         rsp_value_in  = cell_value[0];
         rsp_count_in  = count_x[3:0];
         rsp_last_in   = ((CW'(step_ff) + CW'(1)) == count_ff);
      end
   end

   // per-cell action: insert shifts cells above pos up, delete pulls cells at
   // and above pos down, display rotates the whole row toward cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_ctl
      always_comb begin
         cell_ctl[i].ins_value = req_data_value;
         cell_ctl[i].act       = pidarr_pkg::ACT_HOLD;
         if (ins_ok) begin
            if (IW'(i) == pos_x)
               cell_ctl[i].act = pidarr_pkg::ACT_LOAD;
            else if (IW'(i) > pos_x)
               cell_ctl[i].act = pidarr_pkg::ACT_LEFT;
         end else if (del_ok) begin
            if (!(IW'(i) < pos_x))
               cell_ctl[i].act = pidarr_pkg::ACT_RIGHT;
         end else if (show_adv) begin
            cell_ctl[i].act = pidarr_pkg::ACT_RIGHT;
         end
      end

      pidarr_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .left_value  (cell_value[(i + CAPACITY - 1) % CAPACITY]),
         .right_value (cell_value[(i + 1) % CAPACITY]),
         .value       (cell_value[i])
      );
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidarr_pkg::ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_show_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pidarr_pkg::ST_SHOW) |-> req_stall)
      else $error("request taken during display");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == pidarr_pkg::ST_SHOW))
      else $error("non-final word with no display running");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the count");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      del_ok |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("delete did not shrink the count");

endmodule

`default_nettype wire
